// ===== design/cfd_pkg.sv =====
package cfd_pkg;

    // One received radio byte as it enters the block.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in_packet;
    } t_in_word;

    // One byte of a completed frame as it leaves the block.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] frame_kind;
        logic [6:0] frame_length;
        logic       last_of_frame;
    } t_result;

    // Command from the front classifier to the back executor. The address
    // field is sized for the deepest store the block supports.
    typedef struct packed {
        logic       wr;
        logic [5:0] addr;
        logic [7:0] data;
        logic       emit;
        logic       err;
        logic [1:0] kind;
        logic [6:0] len;
    } t_cmd;

    // Frame kinds reported with each result.
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_RAW   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Second byte range that marks a raw frame.
    localparam logic [7:0] RAW_TYPE_LOW  = 8'h11;
    localparam logic [7:0] RAW_TYPE_HIGH = 8'h14;

    // Smallest legal raw length, also the length reported on a length error.
    localparam logic [7:0] RAW_MIN_LEN   = 8'd3;
    localparam logic [6:0] ERR_FRAME_LEN = 7'd3;

    // Configuration register indexes, taken from address bit 2.
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    // Queue depths.
    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 4;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_READ = 2'b10
    } t_back_state;

endpackage

// ===== design/cfd_front.sv =====
module cfd_front #(
    parameter int STORE_DEPTH      = 64,
    parameter int MAX_PACKET_BYTES = 251
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  cfd_pkg::t_in_word i_item,
    input  logic [7:0]        i_start_marker,
    input  logic [7:0]        i_end_marker,
    output logic              o_cmd_push,
    output cfd_pkg::t_cmd     o_cmd
);

    localparam int WC_W = $clog2(STORE_DEPTH + 1);

    logic [7:0]      r_pos, n_pos;
    logic [WC_W-1:0] r_wc, n_wc;
    logic            r_in_frame, n_in_frame;
    logic            r_raw, n_raw;
    logic [7:0]      r_len, n_len;

    logic [7:0]      c;
    logic            restart;
    logic [WC_W-1:0] wc0;
    logic [WC_W-1:0] wc1;
    logic [7:0]      cur_len;
    logic            bad_len;

    assign c       = i_item.in_byte;
    assign restart = (c == i_start_marker) && !r_raw;
    assign wc0     = restart ? '0 : r_wc;
    assign wc1     = wc0 + WC_W'(1);
    assign cur_len = (wc1 == WC_W'(3)) ? c : r_len;
    assign bad_len = (c < cfd_pkg::RAW_MIN_LEN) || ({1'b0, c} > 9'(STORE_DEPTH));

    // Classify each accepted byte inside a frame into a store write and, where a frame
    // closes, a readout or error command.
    always_comb begin
        n_pos      = r_pos;
        n_wc       = r_wc;
        n_in_frame = r_in_frame;
        n_raw      = r_raw;
        n_len      = r_len;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        if (i_accept) begin
            if (i_item.last_in_packet) begin
                n_pos = '0;
            end else if (r_pos != 8'hFF) begin
                n_pos = r_pos + 8'd1;
            end
            if ((r_pos < 8'(MAX_PACKET_BYTES)) && (r_in_frame || restart)) begin
                o_cmd_push = 1'b1;
                o_cmd.wr   = 1'b1;
                o_cmd.addr = 6'(wc0);
                o_cmd.data = c;
                n_in_frame = 1'b1;
                if (r_raw) begin
                    n_wc = wc1;
                    if (wc1 == WC_W'(3)) begin
                        n_len = c;
                    end
                    if ((wc1 == WC_W'(3)) && bad_len) begin
                        o_cmd.err  = 1'b1;
                        n_in_frame = 1'b0;
                        n_raw      = 1'b0;
                        n_wc       = '0;
                    end else if ((wc1 >= WC_W'(3)) && (8'(wc1) == cur_len)) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = cfd_pkg::KIND_RAW;
                        o_cmd.len  = 7'(wc1);
                        n_in_frame = 1'b0;
                        n_raw      = 1'b0;
                    end
                end else if ((wc1 == WC_W'(2)) && (c >= cfd_pkg::RAW_TYPE_LOW)
                             && (c <= cfd_pkg::RAW_TYPE_HIGH)) begin
                    n_raw = 1'b1;
                    n_wc  = wc1;
                end else if (c == i_end_marker) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = cfd_pkg::KIND_TEXT;
                    o_cmd.len  = 7'(wc1);
                    n_in_frame = 1'b0;
                    n_wc       = wc1;
                end else if (wc1 >= WC_W'(STORE_DEPTH)) begin
                    // A full store keeps overwriting its last slot.
                    n_wc = WC_W'(STORE_DEPTH - 1);
                end else begin
                    n_wc = wc1;
                end
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_wc       <= '0;
            r_in_frame <= 1'b0;
            r_raw      <= 1'b0;
            r_len      <= '0;
        end else begin
            r_pos      <= n_pos;
            r_wc       <= n_wc;
            r_in_frame <= n_in_frame;
            r_raw      <= n_raw;
            r_len      <= n_len;
        end
    end

endmodule

// ===== design/cfd_cmdq.sv =====
module cfd_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cfd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output cfd_pkg::t_cmd o_head
);

    localparam int AW = $clog2(cfd_pkg::CMDQ_DEPTH);

    cfd_pkg::t_cmd r_mem [cfd_pkg::CMDQ_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (AW+1)'(cfd_pkg::CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule

// ===== design/cfd_back.sv =====
module cfd_back #(
    parameter int STORE_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  cfd_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output cfd_pkg::t_result o_result
);

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int QAW = $clog2(cfd_pkg::OUTQ_DEPTH);

    cfd_pkg::t_back_state r_state, n_state;
    logic [AW-1:0]        r_rd_addr, n_rd_addr;
    logic [6:0]           r_len, n_len;
    logic [1:0]           r_kind, n_kind;

    logic [7:0]           r_store [STORE_DEPTH];
    logic [7:0]           r_mem_q;
    logic                 r_rd_valid, n_rd_valid;
    cfd_pkg::t_result     r_rd_meta, n_rd_meta;
    logic                 r_use_direct, n_use_direct;

    cfd_pkg::t_result     r_oq [cfd_pkg::OUTQ_DEPTH];
    logic [QAW-1:0]       r_oq_wp;
    logic [QAW-1:0]       r_oq_rp;
    logic [QAW:0]         r_oq_cnt;

    logic                 can_issue;
    logic                 mem_wr;
    logic                 rd_en;
    logic                 rd_last;
    logic                 oq_pop;
    cfd_pkg::t_result     oq_in;

    // Room in the output queue for everything already in flight.
    assign can_issue = ((r_oq_cnt + (QAW+1)'(r_rd_valid)) < (QAW+1)'(cfd_pkg::OUTQ_DEPTH));
    assign rd_last   = ((7'(r_rd_addr) + 7'd1) == r_len);

    // Sequencer: executes one command at a time; after a readout command it reads the frame out.
    always_comb begin
        n_state      = r_state;
        n_rd_addr    = r_rd_addr;
        n_len        = r_len;
        n_kind       = r_kind;
        n_rd_valid   = 1'b0;
        n_rd_meta    = r_rd_meta;
        n_use_direct = r_use_direct;
        o_cmd_pop    = 1'b0;
        mem_wr       = 1'b0;
        rd_en        = 1'b0;
        case (r_state)
            cfd_pkg::BK_IDLE: begin
                if (i_cmd_valid && (!i_cmd.err || can_issue)) begin
                    o_cmd_pop = 1'b1;
                    mem_wr    = i_cmd.wr;
                    if (i_cmd.err) begin
                        n_rd_valid                = 1'b1;
                        n_use_direct              = 1'b1;
                        n_rd_meta.out_byte        = i_cmd.data;
                        n_rd_meta.frame_kind      = cfd_pkg::KIND_ERROR;
                        n_rd_meta.frame_length    = cfd_pkg::ERR_FRAME_LEN;
                        n_rd_meta.last_of_frame   = 1'b1;
                    end else if (i_cmd.emit) begin
                        n_state   = cfd_pkg::BK_READ;
                        n_rd_addr = '0;
                        n_len     = i_cmd.len;
                        n_kind    = i_cmd.kind;
                    end
                end
            end
            cfd_pkg::BK_READ: begin
                if (can_issue) begin
                    rd_en                   = 1'b1;
                    n_rd_valid              = 1'b1;
                    n_use_direct            = 1'b0;
                    n_rd_meta.out_byte      = '0;
                    n_rd_meta.frame_kind    = r_kind;
                    n_rd_meta.frame_length  = r_len;
                    n_rd_meta.last_of_frame = rd_last;
                    if (rd_last) begin
                        n_state = cfd_pkg::BK_IDLE;
                    end else begin
                        n_rd_addr = r_rd_addr + AW'(1);
                    end
                end
            end
            default: begin
                n_state = cfd_pkg::BK_IDLE;
            end
        endcase
    end

    // Frame store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_store[i_cmd.addr[AW-1:0]] <= i_cmd.data;
        end
        if (rd_en) begin
            r_mem_q <= r_store[r_rd_addr];
        end
    end

    // Sequencer and read stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cfd_pkg::BK_IDLE;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= n_rd_valid;
        end
        r_rd_addr    <= n_rd_addr;
        r_len        <= n_len;
        r_kind       <= n_kind;
        r_rd_meta    <= n_rd_meta;
        r_use_direct <= n_use_direct;
    end

    // Output queue: the read stage lands here and waits for pop.
    always_comb begin
        oq_in = r_rd_meta;
        if (!r_use_direct) begin
            oq_in.out_byte = r_mem_q;
        end
    end

    assign oq_pop   = i_pop && !o_empty;
    assign o_empty  = (r_oq_cnt == '0);
    assign o_result = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (r_rd_valid) begin
            r_oq[r_oq_wp] <= oq_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_rd_valid) begin
                r_oq_wp <= r_oq_wp + QAW'(1);
            end
            if (oq_pop) begin
                r_oq_rp <= r_oq_rp + QAW'(1);
            end
            r_oq_cnt <= r_oq_cnt + (QAW+1)'(r_rd_valid) - (QAW+1)'(oq_pop);
        end
    end

endmodule

// ===== design/command_frame_deframer_top.sv =====
// Accepts one received byte per cycle while the two-entry command queue has room.
// A frame drains through the frame store read port at one result per cycle while the
// output queue has room, via the command queue, sequencer, registered read port and
// output queue. The front stalls only while the back end holds commands back, during
// a readout or while a length error word waits for output room. Synchronous active-low
// reset clears frame state and queues and sets the start and end markers to 60 and 62.
module command_frame_deframer_top #(
    parameter int STORE_DEPTH      = 64,
    parameter int MAX_PACKET_BYTES = 251
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  cfd_pkg::t_in_word i_item,
    output logic              empty,
    input  logic              pop,
    output cfd_pkg::t_result  o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0]    r_start_marker;
    logic [7:0]    r_end_marker;
    logic          accept;
    logic          cmd_push;
    cfd_pkg::t_cmd cmd_in;
    logic          q_valid;
    cfd_pkg::t_cmd q_head;
    logic          q_pop;
    logic          cfg_wr;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == cfd_pkg::REG_END_MARKER) ? {24'd0, r_end_marker}
                                                          : {24'd0, r_start_marker};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= 8'd60;
            r_end_marker   <= 8'd62;
        end else if (cfg_wr) begin
            if (paddr[2] == cfd_pkg::REG_START_MARKER) begin
                r_start_marker <= pwdata[7:0];
            end else begin
                r_end_marker <= pwdata[7:0];
            end
        end
    end

    assign accept = push && !full;

    cfd_front #(
        .STORE_DEPTH      (STORE_DEPTH),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_item         (i_item),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_cmd_push     (cmd_push),
        .o_cmd          (cmd_in)
    );

    cfd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    cfd_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_head),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

    // A length error word is always a single-word frame of length three.
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.frame_kind == cfd_pkg::KIND_ERROR))
        |-> (o_result.last_of_frame && (o_result.frame_length == cfd_pkg::ERR_FRAME_LEN)))
        else $error("length error word malformed");

    // A word that is not the last of its frame belongs to a longer frame.
    a_mid_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.last_of_frame) |-> (o_result.frame_length > 7'd1))
        else $error("non-final word in a one-word frame");

    // A readout command never asks for an empty frame or more than the store holds.
    a_emit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_head.emit)
        |-> ((q_head.len != 7'd0) && (q_head.len <= 7'(STORE_DEPTH))))
        else $error("readout length out of range");

endmodule

// ===== bench/command_frame_deframer_top_tb.sv =====
module command_frame_deframer_top_tb;

    localparam int STORE_DEPTH      = 64;
    localparam int MAX_PACKET_BYTES = 251;

    // Operations of the directed stimulus table.
    typedef enum logic [1:0] {
        ROW_WORD      = 2'd0,
        ROW_SET_START = 2'd1,
        ROW_SET_END   = 2'd2
    } t_row_op;

    // One row of the directed table; res is used only where typed is set.
    typedef struct packed {
        t_row_op          op;
        logic [7:0]       data;
        logic             last;
        logic             typed;
        cfd_pkg::t_result res;
    } t_row;

    localparam cfd_pkg::t_result NO_RES = '0;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              push    = 1'b0;
    logic              full;
    cfd_pkg::t_in_word i_item  = '0;
    logic              empty;
    logic              pop     = 1'b0;
    cfd_pkg::t_result  o_result;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [2:0]        paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Predicted deframer state and marker registers.
    logic [7:0] mk_start = 8'h3C;
    logic [7:0] mk_end   = 8'h3E;
    logic [7:0] fb_store [STORE_DEPTH];
    int         fb_count = 0;
    bit         fb_open  = 1'b0;
    bit         fb_raw   = 1'b0;
    int         pkt_pos  = 0;

    cfd_pkg::t_result  frame_bytes_due [$];
    cfd_pkg::t_in_word plan [$];
    bit                calm          = 1'b0;
    bit                mismatch_seen = 1'b0;

    // Directed stimulus: extremes, raw length errors, restart, marker corner cases.
    t_row dir_tab [29] = '{
        '{ROW_WORD, 8'h3C, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h00, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'hFF, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h3E, 1'b1, 1'b0, NO_RES},
        '{ROW_WORD, 8'h3C, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h11, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h02, 1'b0, 1'b1,
          '{8'h02, cfd_pkg::KIND_ERROR, cfd_pkg::ERR_FRAME_LEN, 1'b1}},
        '{ROW_WORD, 8'h3C, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h14, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h41, 1'b1, 1'b1,
          '{8'h41, cfd_pkg::KIND_ERROR, cfd_pkg::ERR_FRAME_LEN, 1'b1}},
        '{ROW_WORD, 8'h3C, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h12, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h04, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h3C, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h3C, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h78, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h3C, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h79, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h3E, 1'b1, 1'b0, NO_RES},
        '{ROW_SET_END, 8'h13, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h3C, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h13, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h03, 1'b0, 1'b0, NO_RES},
        '{ROW_SET_START, 8'hFF, 1'b0, 1'b0, NO_RES},
        '{ROW_SET_END, 8'hFF, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'hFF, 1'b1, 1'b1, '{8'hFF, cfd_pkg::KIND_TEXT, 7'd1, 1'b1}},
        '{ROW_SET_START, 8'h00, 1'b0, 1'b0, NO_RES},
        '{ROW_SET_END, 8'h00, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'h00, 1'b0, 1'b1, '{8'h00, cfd_pkg::KIND_TEXT, 7'd1, 1'b1}}
    };

    command_frame_deframer_top #(
        .STORE_DEPTH      (STORE_DEPTH),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Queue every stored byte of the finished frame as expected output words.
    function automatic int emit_frame_bytes(input logic [1:0] kind);
        int               cnt;
        cfd_pkg::t_result r;
        cnt = (fb_count > STORE_DEPTH) ? STORE_DEPTH : fb_count;
        for (int k = 0; k < cnt; k++) begin
            r.out_byte      = fb_store[k];
            r.frame_kind    = kind;
            r.frame_length  = cnt[6:0];
            r.last_of_frame = (k == cnt - 1);
            frame_bytes_due.push_back(r);
        end
        return cnt;
    endfunction

    // Advance the predicted deframer by one received byte; returns words queued.
    function automatic int predict_deframe(input logic [7:0] c, input logic lst);
        int               n;
        cfd_pkg::t_result r;
        n = 0;
        if (pkt_pos < MAX_PACKET_BYTES) begin
            if (c == mk_start && !fb_raw) begin
                fb_open  = 1'b1;
                fb_count = 0;
            end
            if (fb_open) begin
                if (fb_count < STORE_DEPTH) begin
                    fb_store[fb_count] = c;
                end
                fb_count++;
                if (fb_raw) begin
                    // The length byte is judged as soon as it lands.
                    if (fb_count == 3 &&
                        (fb_store[2] < cfd_pkg::RAW_MIN_LEN || fb_store[2] > STORE_DEPTH)) begin
                        r = '{fb_store[2], cfd_pkg::KIND_ERROR, cfd_pkg::ERR_FRAME_LEN, 1'b1};
                        frame_bytes_due.push_back(r);
                        n        = 1;
                        fb_open  = 1'b0;
                        fb_raw   = 1'b0;
                        fb_count = 0;
                    end else if (fb_count >= 3 && fb_count == fb_store[2]) begin
                        n       = emit_frame_bytes(cfd_pkg::KIND_RAW);
                        fb_open = 1'b0;
                        fb_raw  = 1'b0;
                    end
                end else if (fb_count == 2 && fb_store[1] >= cfd_pkg::RAW_TYPE_LOW &&
                             fb_store[1] <= cfd_pkg::RAW_TYPE_HIGH) begin
                    fb_raw = 1'b1;
                end else if (c == mk_end) begin
                    n       = emit_frame_bytes(cfd_pkg::KIND_TEXT);
                    fb_open = 1'b0;
                end else if (fb_count >= STORE_DEPTH) begin
                    // A full text store keeps overwriting its last slot.
                    fb_count = STORE_DEPTH - 1;
                end
            end
        end
        if (lst) begin
            pkt_pos = 0;
        end else if (pkt_pos < 255) begin
            pkt_pos++;
        end
        return n;
    endfunction

    // Compare one accepted output word with the oldest pending expectation.
    function automatic void check_result(input cfd_pkg::t_result got);
        cfd_pkg::t_result want;
        if (frame_bytes_due.size() == 0) begin
            $error("unexpected output word: out_byte %0h", got.out_byte);
            mismatch_seen = 1'b1;
        end else begin
            want = frame_bytes_due.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
                mismatch_seen = 1'b1;
            end
            if (got.frame_kind !== want.frame_kind) begin
                $error("frame_kind: expected %0d, actual %0d",
                       want.frame_kind, got.frame_kind);
                mismatch_seen = 1'b1;
            end
            if (got.frame_length !== want.frame_length) begin
                $error("frame_length: expected %0d, actual %0d",
                       want.frame_length, got.frame_length);
                mismatch_seen = 1'b1;
            end
            if (got.last_of_frame !== want.last_of_frame) begin
                $error("last_of_frame: expected %0d, actual %0d",
                       want.last_of_frame, got.last_of_frame);
                mismatch_seen = 1'b1;
            end
        end
    endfunction

    function automatic void plan_word(input logic [7:0] b, input logic lst);
        cfd_pkg::t_in_word w;
        w.in_byte        = b;
        w.last_in_packet = lst;
        plan.push_back(w);
    endfunction

    // Offer one word after a random gap and hold it until the block takes it.
    task automatic send_word(input logic [7:0] b, input logic lst, output int n);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= {b, lst};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n = predict_deframe(b, lst);
    endtask

    // Stop offering words, wait for every expected word, then let the pipe empty.
    task automatic settle();
        push <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Write one marker register over the bus and read it back.
    task automatic set_marker(input logic idx, input logic [7:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == cfd_pkg::REG_START_MARKER) begin
            mk_start = val;
        end else begin
            mk_end = val;
        end
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {24'd0, val}) begin
            $error("prdata: expected %0h, actual %0h", {24'd0, val}, prdata);
            mismatch_seen = 1'b1;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: pop after a random stall and check each word taken.
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 3);
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            check_result(o_result);
        end
    end

    // Main stimulus: directed table, then random phases.
    initial begin
        int         n;
        int         counted;
        int         len;
        int         pick;
        logic [7:0] b;
        logic [7:0] s;
        logic [7:0] e;
        t_row       row;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            row = dir_tab[k];
            case (row.op)
                ROW_WORD: begin
                    send_word(row.data, row.last, n);
                    if (row.typed) begin
                        repeat (n) void'(frame_bytes_due.pop_back());
                        frame_bytes_due.push_back(row.res);
                    end
                end
                ROW_SET_START: begin
                    settle();
                    set_marker(cfd_pkg::REG_START_MARKER, row.data);
                end
                default: begin
                    settle();
                    set_marker(cfd_pkg::REG_END_MARKER, row.data);
                end
            endcase
        end

        // Random phases, each under its own marker setting.
        for (int phase = 0; phase < 5; phase++) begin
            settle();
            case (phase)
                0: begin
                    s = 8'h3C;
                    e = 8'h3E;
                end
                1: begin
                    s = 8'h00;
                    e = 8'hFF;
                end
                2: begin
                    s = 8'hFF;
                    e = 8'h00;
                end
                3: begin
                    s = 8'($urandom_range(0, 255));
                    e = 8'($urandom_range(0, 255));
                end
                default: begin
                    s = 8'($urandom_range(0, 255));
                    e = s;
                end
            endcase
            set_marker(cfd_pkg::REG_START_MARKER, s);
            set_marker(cfd_pkg::REG_END_MARKER, e);
            calm    = (phase == 3);
            counted = 0;
            while (counted < 12) begin
                pick = $urandom_range(0, 9);
                if (pick <= 3) begin
                    // Text frame, now and then long enough to overflow the store.
                    plan_word(mk_start, $urandom_range(0, 7) == 0);
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                      : $urandom_range(0, 8);
                    repeat (len) begin
                        b = 8'($urandom_range(0, 255));
                        if ($urandom_range(0, 15) == 0) b = mk_start;
                        plan_word(b, $urandom_range(0, 7) == 0);
                    end
                    plan_word(mk_end, $urandom_range(0, 7) == 0);
                    counted += plan.size();
                end else if (pick <= 6) begin
                    // Raw frame with a mostly legal length byte.
                    plan_word(mk_start, $urandom_range(0, 7) == 0);
                    plan_word(8'($urandom_range(cfd_pkg::RAW_TYPE_LOW, cfd_pkg::RAW_TYPE_HIGH)),
                              $urandom_range(0, 7) == 0);
                    len = $urandom_range(0, 9);
                    if (len < 7) begin
                        len = $urandom_range(3, 10);
                    end else if (len == 7) begin
                        len = STORE_DEPTH;
                    end else if (len == 8) begin
                        len = $urandom_range(0, 2);
                    end else begin
                        len = $urandom_range(STORE_DEPTH + 1, 255);
                    end
                    plan_word(len[7:0], $urandom_range(0, 7) == 0);
                    if (len >= 3 && len <= STORE_DEPTH) begin
                        repeat (len - 3) begin
                            b = 8'($urandom_range(0, 255));
                            if ($urandom_range(0, 7) == 0) b = mk_start;
                            plan_word(b, $urandom_range(0, 7) == 0);
                        end
                    end
                    counted += plan.size();
                end else if (pick == 7) begin
                    // Unterminated frame, left to be restarted or ignored.
                    plan_word(mk_start, $urandom_range(0, 7) == 0);
                    repeat ($urandom_range(0, 3)) begin
                        plan_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                    end
                    counted += plan.size();
                end else begin
                    // Line noise between frames.
                    repeat ($urandom_range(1, 4)) begin
                        plan_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                    end
                end
                foreach (plan[k]) begin
                    send_word(plan[k].in_byte, plan[k].last_in_packet, n);
                end
                plan.delete();
            end
        end

        settle();
        if (!mismatch_seen) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop for a hung run.
    initial begin
        #(20 * 600000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/cfd_pkg.sv
design/cfd_front.sv
design/cfd_cmdq.sv
design/cfd_back.sv
design/command_frame_deframer_top.sv
bench/command_frame_deframer_top_tb.sv
